/* hdl/dxt_texture_block_encoder_top_assert.svh */
// assertion macros for the block encoder
`ifndef DXT_TEXTURE_BLOCK_ENCODER_TOP_ASSERT_SVH
`define DXT_TEXTURE_BLOCK_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DXT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define DXT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define DXT_ASSERT_IMP(label, clk, rst, ante, cons)
`define DXT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/dxt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dxt_pkg;
   localparam int NumPix = 16;
   localparam logic       ModeReset  = 1'b1;
   localparam logic [3:0] ShiftReset = 4'd4;
   localparam logic       CsrMode    = 1'b0;
   localparam logic       CsrShift   = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } req_type;

   typedef struct packed {
      logic [63:0] block_word;
      logic        last;
   } rsp_type;

   typedef logic [6:0][7:0]      thr_type;
   typedef logic [3:0][2:0][7:0] pal_type;

   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'd683;
      return p[18:11];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [25:0] p;
      p = 26'(x) * 26'd4682;
      return p[22:15];
   endfunction

   function automatic logic [7:0] div14(input logic [7:0] x);
      logic [23:0] p;
      p = 24'(x) * 24'd4682;
      return p[23:16];
   endfunction
endpackage
`default_nettype wire

/* hdl/dxt_pixel_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module dxt_pixel_cell (
   input  wire logic        clock,
   input  wire logic        shift_en,
   input  wire logic [31:0] pix_in,
   output logic      [31:0] pix_out
);
   logic [31:0] pix_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_out = pix_ff;
endmodule
`default_nettype wire

/* hdl/dxt_idx_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
module dxt_idx_unit (
   input  wire logic [31:0]        pix,
   input  wire dxt_pkg::thr_type   thr,
   input  wire dxt_pkg::pal_type   pal,
   output logic      [2:0]         alpha_idx,
   output logic      [1:0]         color_idx
);
   logic [2:0] n;
   logic [2:0] a_idx;
   logic [3:0][9:0] d;
   logic [7:0] px;

   always_comb begin
      n = '0;
      for (int k = 0; k < 7; k++) begin
         if (pix[31:24] <= thr[k]) begin
            n = n + 3'd1;
         end
      end
      a_idx = n + 3'd1;
      if (a_idx < 3'd2) begin
         a_idx = a_idx ^ 3'd1;
      end
      alpha_idx = a_idx;
   end

   always_comb begin
      for (int e = 0; e < 4; e++) begin
         d[e] = '0;
         for (int c = 0; c < 3; c++) begin
            px = pix[8*c +: 8];
            d[e] = d[e] + 10'((pal[e][c] > px) ? (pal[e][c] - px) : (px - pal[e][c]));
         end
      end
      color_idx[0] = (d[0] > d[3]) && (d[2] > d[3]);
      color_idx[1] = ((d[1] > d[2]) && (d[0] > d[2])) || ((d[0] > d[3]) && (d[1] > d[3]));
   end
endmodule
`default_nettype wire

/* hdl/dxt_texture_block_encoder_top.sv */
// channel  | ports                       | carries
// req      | req_valid req_ready req_data | one rgba pixel, raster order
// rsp      | rsp_valid rsp_ready rsp_data | 64-bit compressed word, last flag
// csr      | csr_we csr_index csr_wdata   | mode and inset shift writes
// sixteen pixels load a 16-cell pixel chain, then two setup states (inset,
// then thresholds and palette), then an index state shifting all sixteen
// pixels through one index unit, then one or two words; no new pixel is
// accepted until the last word leaves
// synchronous reset clears the count and bounds and sets state, output valid, mode and shift to defaults
`timescale 1ns / 1ps
`default_nettype none
`include "dxt_texture_block_encoder_top_assert.svh"
module dxt_texture_block_encoder_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dxt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dxt_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [3:0]       csr_wdata
);
   typedef enum logic [2:0] {
      ST_LOAD, ST_INSET, ST_PREP, ST_INDEX, ST_ALPHA, ST_COLOR
   } state_type;

   state_type state_ff;
   logic [3:0] cnt_ff;
   logic mode_ff, bmode_ff;
   logic [3:0] shift_ff, bshift_ff;
   logic [3:0][7:0] min_ff, max_ff, lo_ff, hi_ff;
   logic [3:0][7:0] min_in, max_in;
   dxt_pkg::thr_type thr_ff, thr_in;
   dxt_pkg::pal_type pal_ff, pal_in;
   logic [47:0] aidx_ff;
   logic [31:0] cidx_ff;
   logic rsp_valid_ff;
   dxt_pkg::rsp_type rsp_data_ff;
   logic accept, shift_en, rsp_take;
   logic [31:0] req_pix;
   logic [16:0][31:0] chain;
   logic [2:0] a_idx;
   logic [1:0] c_idx;
   logic [3:0][7:0] lo_in, hi_in;
   logic [7:0] ins, mid;
   logic [8:0] sum9;
   logic [7:0] c0, c1;
   logic [15:0] max565, min565;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_pix   = {req_data.alpha, req_data.blue, req_data.green, req_data.red};
   assign shift_en  = accept || (state_ff == ST_INDEX);
   assign chain[16] = (state_ff == ST_LOAD) ? req_pix : chain[0];

   for (genvar i = 0; i < dxt_pkg::NumPix; i++) begin : g_cell
      dxt_pixel_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .pix_in   (chain[i+1]),
         .pix_out  (chain[i])
      );
   end

   dxt_idx_unit u_idx (
      .pix       (chain[0]),
      .thr       (thr_ff),
      .pal       (pal_ff),
      .alpha_idx (a_idx),
      .color_idx (c_idx)
   );

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         min_in[c] = (req_pix[8*c +: 8] < min_ff[c]) ? req_pix[8*c +: 8] : min_ff[c];
         max_in[c] = (req_pix[8*c +: 8] > max_ff[c]) ? req_pix[8*c +: 8] : max_ff[c];
      end
   end

   always_comb begin
      ins  = '0;
      sum9 = '0;
      for (int c = 0; c < 4; c++) begin
         ins = (bshift_ff >= 4'd8) ? 8'd0 : (8'(max_ff[c] - min_ff[c]) >> bshift_ff);
         sum9 = 9'(min_ff[c]) + 9'(ins);
         lo_in[c] = sum9[8] ? 8'hFF : sum9[7:0];
         hi_in[c] = (max_ff[c] >= ins) ? 8'(max_ff[c] - ins) : 8'd0;
      end
   end

   always_comb begin
      if (hi_ff[3] >= lo_ff[3]) begin
         mid = dxt_pkg::div14(8'(hi_ff[3] - lo_ff[3]));
      end else begin
         mid = 8'(8'd0 - dxt_pkg::div14(8'(lo_ff[3] - hi_ff[3])));
      end
      thr_in[0] = 8'(lo_ff[3] + mid);
      for (int k = 1; k < 7; k++) begin
         thr_in[k] = 8'(dxt_pkg::div7(11'(11'(7 - k) * 11'(hi_ff[3]) + 11'(k) * 11'(lo_ff[3])))
                        + mid);
      end
      c0 = '0;
      c1 = '0;
      for (int c = 0; c < 3; c++) begin
         if (c == 1) begin
            c0 = (hi_ff[c] & 8'hFC) | (hi_ff[c] >> 6);
            c1 = (lo_ff[c] & 8'hFC) | (lo_ff[c] >> 6);
         end else begin
            c0 = (hi_ff[c] & 8'hF8) | (hi_ff[c] >> 5);
            c1 = (lo_ff[c] & 8'hF8) | (lo_ff[c] >> 5);
         end
         pal_in[0][c] = c0;
         pal_in[1][c] = c1;
         pal_in[2][c] = dxt_pkg::div3(10'({c0, 1'b0}) + 10'(c1));
         pal_in[3][c] = dxt_pkg::div3(10'(c0) + 10'({c1, 1'b0}));
      end
   end

   assign max565 = {hi_ff[0][7:3], hi_ff[1][7:2], hi_ff[2][7:3]};
   assign min565 = {lo_ff[0][7:3], lo_ff[1][7:2], lo_ff[2][7:3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (accept) begin
                  cnt_ff <= cnt_ff + 4'd1;
                  if (cnt_ff == 4'd15) begin
                     state_ff <= ST_INSET;
                  end
               end
            end
            ST_INSET: state_ff <= ST_PREP;
            ST_PREP:  state_ff <= ST_INDEX;
            ST_INDEX: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  rsp_valid_ff <= 1'b1;
                  if (bmode_ff) begin
                     rsp_data_ff.block_word <= {a_idx, aidx_ff[47:3], lo_ff[3], hi_ff[3]};
                     rsp_data_ff.last       <= 1'b0;
                     state_ff               <= ST_ALPHA;
                  end else begin
                     rsp_data_ff.block_word <= {c_idx, cidx_ff[31:2], min565, max565};
                     rsp_data_ff.last       <= 1'b1;
                     state_ff               <= ST_COLOR;
                  end
               end
            end
            ST_ALPHA: begin
               if (rsp_take) begin
                  rsp_data_ff <= '{block_word: {cidx_ff, min565, max565}, last: 1'b1};
                  state_ff    <= ST_COLOR;
               end
            end
            ST_COLOR: begin
               if (rsp_take) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= dxt_pkg::ModeReset;
         shift_ff <= dxt_pkg::ShiftReset;
         min_ff   <= '1;
         max_ff   <= '0;
      end else begin
         if (csr_we) begin
            if (csr_index == dxt_pkg::CsrMode) begin
               mode_ff <= csr_wdata[0];
            end else begin
               shift_ff <= csr_wdata;
            end
         end
         if (accept) begin
            min_ff <= min_in;
            max_ff <= max_in;
            if (cnt_ff == 4'd15) begin
               bmode_ff  <= mode_ff;
               bshift_ff <= shift_ff;
            end
         end else if (rsp_take && state_ff == ST_COLOR) begin
            min_ff <= '1;
            max_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_INSET) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (state_ff == ST_PREP) begin
         thr_ff <= thr_in;
         pal_ff <= pal_in;
      end
      if (state_ff == ST_INDEX) begin
         aidx_ff <= {a_idx, aidx_ff[47:3]};
         cidx_ff <= {c_idx, cidx_ff[31:2]};
      end
   end

   `DXT_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `DXT_ASSERT_IMP(a_alpha_mode, clock, reset, rsp_valid && !rsp_data.last, bmode_ff)
   `DXT_ASSERT_NXT(a_block_done, clock, reset, rsp_valid && rsp_ready && rsp_data.last, req_ready && cnt_ff == 4'd0 && max_ff == '0)
endmodule
`default_nettype wire
